### src/nlts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlts_pkg
// Shared types, codes and constants for the nearest light table select block.
// ----------------------------------------------------------------------------
package nlts_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned MaxSelectedDefault = 3;

  localparam int unsigned InWidth = 136;   // 129 bits of fields, padded to bytes
  localparam int unsigned OutWidth = 128;  // 123 bits of fields, padded to bytes
  localparam int unsigned DistWidth = 35;  // sum of three 17-bit squares
  localparam int unsigned LifeWidth = 24;

  localparam logic [1:0] ActCreate = 2'd0;
  localparam logic [1:0] ActDelete = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;
  localparam logic [1:0] ActQuery = 2'd3;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatFull = 2'd1;
  localparam logic [1:0] StatNoSlot = 2'd2;

  // stored record of one light: pos x,y,z, range, power r,g,b, manual flag
  localparam int unsigned RecWidth = 16 * 7 + 1;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the input word
    logic scan_clr;    // clear counter and selection list
    logic scan_step;   // advance scan address
    logic eval;        // evaluate the entry read last cycle
    logic res_load;    // build a result word
    logic res_next;    // advance result index
  } nlts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_done;  // last address issued
    logic       res_last;   // current result is the final one
  } nlts_sts_t;

endpackage

### src/nearest_light_table_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_light_table_select
// Point light table with create, delete, lifetime tick and nearest-3 query.
// A word is taken in the idle state, then one scan runs over every table
// address, followed by a drain state that evaluates the final entry and a
// build state that forms the first result word, held until it is taken.
// Each further result word passes through build and send again; a new word
// is accepted only after the last result word has been taken.
// Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_light_table_select #(
  parameter int unsigned TableDepth = nlts_pkg::TableDepthDefault,
  parameter int unsigned MaxSelected = nlts_pkg::MaxSelectedDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action, slot, pos_x, pos_y, pos_z, reach, color_r, color_g, color_b,
  // intensity, time_value, manual_delete
  input  logic [nlts_pkg::InWidth-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, slot_out, light_x, light_y, light_z, light_range, power_r,
  // power_g, power_b, found_count, light_found
  output logic [nlts_pkg::OutWidth-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import nlts_pkg::*;

  nlts_cmd_t cmd;
  nlts_sts_t sts;

  nlts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .sts_i(sts), .cmd_o(cmd)
  );

  nlts_dp #(.TableDepth(TableDepth), .MaxSelected(MaxSelected)) u_dp (
    .clk_i, .rst_ni,
    .in_word_i(s_axis_tdata), .cmd_i(cmd), .sts_o(sts),
    .out_word_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );

endmodule

### src/nlts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlts_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module nlts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/nlts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlts_ctrl
// Sequencer: takes a word, runs the table scan, then emits the result words.
// ----------------------------------------------------------------------------
module nlts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  nlts_pkg::nlts_sts_t sts_i,
  output nlts_pkg::nlts_cmd_t cmd_o
);
  import nlts_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StBuild = 3'd3;
  localparam logic [2:0] StSend = 3'd4;

  logic [2:0] state_q, state_d;
  logic       tail_q, tail_d;  // evaluation of the previously issued address pending

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tail_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tail_q <= tail_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tail_d = 1'b0;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.eval = tail_q;
        if (sts_i.scan_done) begin
          state_d = StDrain;
        end else begin
          tail_d = 1'b1;
        end
      end
      StDrain: begin
        cmd_o.eval = 1'b1;
        state_d = StBuild;
      end
      StBuild: begin
        cmd_o.res_load = 1'b1;
        state_d = StSend;
      end
      StSend: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.res_last) begin
            state_d = StIdle;
          end else begin
            cmd_o.res_next = 1'b1;
            state_d = StBuild;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

### src/nlts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlts_dp
// Datapath: light table storage, distance unit, sorted selection list and
// result word formatting.
// ----------------------------------------------------------------------------
module nlts_dp #(
  parameter int unsigned TableDepth = nlts_pkg::TableDepthDefault,
  parameter int unsigned MaxSelected = nlts_pkg::MaxSelectedDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [nlts_pkg::InWidth-1:0]     in_word_i,
  input  nlts_pkg::nlts_cmd_t              cmd_i,
  output nlts_pkg::nlts_sts_t              sts_o,
  output logic [nlts_pkg::OutWidth-1:0]    out_word_o,
  output logic                             out_last_o
);
  import nlts_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned SW = (MaxSelected > 1) ? $clog2(MaxSelected) : 1;
  localparam int unsigned NW = $clog2(MaxSelected + 1);

  // captured input fields
  logic [1:0]  act_q;
  logic [5:0]  slot_q;
  logic [15:0] px_q, py_q, pz_q, reach_q;
  logic [7:0]  cr_q, cg_q, cb_q, inten_q;
  logic [23:0] tval_q;
  logic        man_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_word_i[1:0];
      slot_q <= in_word_i[7:2];
      px_q <= in_word_i[23:8];
      py_q <= in_word_i[39:24];
      pz_q <= in_word_i[55:40];
      reach_q <= in_word_i[71:56];
      cr_q <= in_word_i[79:72];
      cg_q <= in_word_i[87:80];
      cb_q <= in_word_i[95:88];
      inten_q <= in_word_i[103:96];
      tval_q <= in_word_i[127:104];
      man_q <= in_word_i[128];
    end
  end

  // scan counter, one address per cycle, with the evaluation address registered behind it
  logic [AW-1:0] addr_q, eaddr_q;
  logic [TableDepth-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      eaddr_q <= '0;
    end else if (cmd_i.scan_clr) begin
      addr_q <= '0;
    end else if (cmd_i.scan_step) begin
      eaddr_q <= addr_q;
      addr_q <= addr_q + AW'(1);
    end
  end

  assign sts_o.scan_done = (addr_q == AW'(TableDepth - 1));

  // record and lifetime memories, read during scan
  logic [RecWidth-1:0]  rec_rd, rec_wd;
  logic [LifeWidth-1:0] life_rd, life_wd;
  logic                 rec_we, life_we;
  logic [AW-1:0]        life_wa;
  logic [15:0]          pr, pg, pb;

  assign pr = 16'(cr_q * inten_q);
  assign pg = 16'(cg_q * inten_q);
  assign pb = 16'(cb_q * inten_q);
  assign rec_wd = {man_q, pb, pg, pr, reach_q, pz_q, py_q, px_q};

  // create target: first free slot in ascending order
  logic [AW-1:0] free_slot;
  logic          free_any;
  always_comb begin
    free_slot = '0;
    free_any = 1'b0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = AW'(i);
        free_any = 1'b1;
      end
    end
  end

  // create writes when its result word is built (free_slot captured on load)
  logic [AW-1:0] new_slot_q;
  logic          new_ok_q;
  logic          created_q;
  logic [SW-1:0] res_idx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_slot_q <= free_slot;
      new_ok_q <= free_any;
    end
  end
  assign rec_we = cmd_i.res_load && act_q == ActCreate && new_ok_q && !res_idx_q[0]
                  && !created_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) created_q <= 1'b0;
    else if (cmd_i.load) created_q <= 1'b0;
    else if (rec_we) created_q <= 1'b1;
  end

  nlts_ram #(.Width(RecWidth), .Depth(TableDepth)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(new_slot_q), .wdata_i(rec_wd),
    .raddr_i(addr_q), .rdata_o(rec_rd)
  );

  // tick ages the entry under evaluation
  logic tick_hit;
  logic [LifeWidth-1:0] life_new;
  assign tick_hit = cmd_i.eval && act_q == ActTick && valid_q[eaddr_q] && life_rd != '0;
  assign life_new = (life_rd > tval_q) ? life_rd - tval_q : '0;
  assign life_we = rec_we || tick_hit;
  assign life_wa = rec_we ? new_slot_q : eaddr_q;
  assign life_wd = rec_we ? tval_q : life_new;

  nlts_ram #(.Width(LifeWidth), .Depth(TableDepth)) u_life (
    .clk_i, .we_i(life_we), .waddr_i(life_wa), .wdata_i(life_wd),
    .raddr_i(addr_q), .rdata_o(life_rd)
  );

  // distance of the record under evaluation, squares and sum in the eval cycle
  logic signed [16:0] dx, dy, dz;
  logic [33:0] sx, sy, sz;
  logic [DistWidth-1:0] dist_sum;
  logic [31:0] rr;
  logic in_range;
  assign dx = 17'($signed(rec_rd[15:0])) - 17'($signed(px_q));
  assign dy = 17'($signed(rec_rd[31:16])) - 17'($signed(py_q));
  assign dz = 17'($signed(rec_rd[47:32])) - 17'($signed(pz_q));
  assign sx = 34'(dx * dx);
  assign sy = 34'(dy * dy);
  assign sz = 34'(dz * dz);
  assign dist_sum = DistWidth'(sx) + DistWidth'(sy) + DistWidth'(sz);
  assign rr = rec_rd[63:48] * rec_rd[63:48];
  assign in_range = dist_sum < DistWidth'(rr);

  // sorted selection list
  logic [DistWidth-1:0] best_d_q [MaxSelected];
  logic [AW-1:0]        best_i_q [MaxSelected];
  logic [NW-1:0]        n_q;
  logic                 take;
  logic [MaxSelected-1:0] lt;

  assign take = cmd_i.eval && act_q == ActQuery && valid_q[eaddr_q] && in_range;
  always_comb begin
    for (int k = 0; k < MaxSelected; k++) begin
      lt[k] = (NW'(k) >= n_q) || (dist_sum < best_d_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.scan_clr) begin
      n_q <= '0;
    end else if (take && lt[MaxSelected-1]) begin
      if (n_q != NW'(MaxSelected)) n_q <= n_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int k = MaxSelected - 1; k >= 0; k--) begin
        if (lt[k]) begin
          if (k == 0 || !lt[k-1]) begin
            best_d_q[k] <= dist_sum;
            best_i_q[k] <= eaddr_q;
          end else begin
            best_d_q[k] <= best_d_q[k-1];
            best_i_q[k] <= best_i_q[k-1];
          end
        end
      end
    end
  end

  // valid bits
  logic del_ok;
  assign del_ok = (32'(slot_q) < TableDepth) && valid_q[AW'(slot_q)];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rec_we) valid_q[new_slot_q] <= 1'b1;
      if (tick_hit && life_new == '0 && !rec_rd[RecWidth-1]) valid_q[eaddr_q] <= 1'b0;
      if (cmd_i.res_load && act_q == ActDelete && del_ok && !created_q)
        valid_q[AW'(slot_q)] <= 1'b0;
    end
  end

  // result index and reported record read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_idx_q <= '0;
    else if (cmd_i.scan_clr) res_idx_q <= '0;
    else if (cmd_i.res_next) res_idx_q <= res_idx_q + SW'(1);
  end

  logic [RecWidth-1:0] rep_rd;
  logic [AW-1:0] rep_addr;
  assign rep_addr = best_i_q[res_idx_q];
  nlts_ram #(.Width(RecWidth), .Depth(TableDepth)) u_rep (
    .clk_i, .we_i(rec_we), .waddr_i(new_slot_q), .wdata_i(rec_wd),
    .raddr_i(rep_addr), .rdata_o(rep_rd)
  );

  logic last_w;
  assign last_w = (act_q != ActQuery) || n_q == '0 || (NW'(res_idx_q) + NW'(1) == n_q);
  assign sts_o.res_last = last_w;

  // result word: status, slot, x, y, z, range, pr, pg, pb, count, found
  logic [1:0] st_w;
  logic [5:0] so_w;
  logic       show;
  logic       hold_q;
  always_comb begin
    st_w = StatOk;
    so_w = '0;
    show = 1'b0;
    case (act_q)
      ActCreate: begin
        st_w = new_ok_q ? StatOk : StatFull;
        so_w = new_ok_q ? 6'(new_slot_q) : '0;
      end
      ActDelete: begin
        st_w = (del_ok || hold_q) ? StatOk : StatNoSlot;
        so_w = slot_q;
      end
      ActTick: ;
      ActQuery: begin
        show = n_q != '0;
        so_w = show ? 6'(rep_addr) : '0;
      end
      default: ;
    endcase
  end

  // delete status is held once the bit has been cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_q <= 1'b0;
    else if (cmd_i.load) hold_q <= 1'b0;
    else if (cmd_i.res_load && act_q == ActDelete && del_ok) hold_q <= 1'b1;
  end

  logic [1:0]  st_q;
  logic [5:0]  so_q;
  logic        show_q;
  logic [1:0]  cnt_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      st_q <= st_w;
      so_q <= so_w;
      show_q <= show;
      cnt_q <= (act_q == ActQuery) ? 2'(n_q) : 2'b0;
      out_last_o <= last_w;
    end
  end

  // record memory read lands in the cycle after res_load, when the word is shown
  logic [111:0] lf;
  assign lf = show_q ? rep_rd[111:0] : '0;
  assign out_word_o = {5'b0, show_q, cnt_q, lf, so_q, st_q};

endmodule

### src/nlts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlts_checker
// Port level checks for nearest_light_table_select.
// ----------------------------------------------------------------------------
module nlts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [nlts_pkg::OutWidth-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // never takes a word while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken during output");

  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // a result word without a light is always the last one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[122] |-> m_axis_tlast)
    else $error("non-light result not last");

  // reported count nonzero whenever a light is carried
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[122] |-> m_axis_tdata[121:120] != 2'b00)
    else $error("light without count");

endmodule

bind nearest_light_table_select nlts_checker u_nlts_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
